[hdl/stcg_pkg.sv]
// shared constants, register codes, config struct and sequencer states for the clip generator
package stcg_pkg;

	localparam int COORD_BITS_DEF         = 12;
	localparam int PROGRESS_FRAC_BITS_DEF = 16;

	localparam int DT_BITS        = 16;
	localparam int RATE_BITS      = 16;
	localparam int MODE_BITS      = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	// dt is Q0.16 and rate is Q8.8, so their product has 24 fraction bits
	localparam int RATE_POINT     = 24;

	localparam logic [MODE_BITS-1:0] MODE_IRIS_IN    = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_IRIS_OUT   = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_HWIPE_IN   = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_HWIPE_OUT  = 3'd3;
	localparam logic [MODE_BITS-1:0] MODE_VWIPE_IN   = 3'd4;
	localparam logic [MODE_BITS-1:0] MODE_VWIPE_OUT  = 3'd5;
	localparam logic [MODE_BITS-1:0] MODE_NONE       = 3'd6;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DISPLAY_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSITION_MODE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIPE_ORIGIN_FAR = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PROGRESS_RATE   = 3'd4;

	localparam int                   RST_DISPLAY_WIDTH  = 320;
	localparam int                   RST_DISPLAY_HEIGHT = 144;
	localparam logic [RATE_BITS-1:0] RST_PROGRESS_RATE  = 16'd256;

	typedef struct packed {
		logic [CFG_DATA_BITS-1:0] display_width;
		logic [CFG_DATA_BITS-1:0] display_height;
		logic [MODE_BITS-1:0]     transition_mode;
		logic                     wipe_origin_far;
		logic [RATE_BITS-1:0]     progress_rate;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADV,
		ST_UPD,
		ST_IRX,
		ST_IRY,
		ST_SQ,
		ST_CUB,
		ST_EASE,
		ST_SCL,
		ST_FIN
	} state_t;

endpackage

[hdl/stcg_in_if.sv]
// tick channel: restart flag and elapsed time
interface stcg_in_if;
	logic                           valid;
	logic                           ready;
	logic                           restart;
	logic [stcg_pkg::DT_BITS-1:0]   tick_dt;

	modport source (output valid, restart, tick_dt, input ready);
	modport sink (input valid, restart, tick_dt, output ready);
endinterface

[hdl/stcg_out_if.sv]
// clip channel: clip rectangle and finished flag
interface stcg_out_if #(
	parameter int COORD_W = stcg_pkg::COORD_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] clip_x;
	logic [COORD_W-1:0] clip_y;
	logic [COORD_W-1:0] clip_w;
	logic [COORD_W-1:0] clip_h;
	logic               finished;

	modport source (output valid, clip_x, clip_y, clip_w, clip_h, finished, input ready);
	modport sink (input valid, clip_x, clip_y, clip_w, clip_h, finished, output ready);
endinterface

[hdl/stcg_cfg.sv]
// configuration registers of the clip generator
module stcg_cfg #(
	parameter int COORD_BITS = stcg_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stcg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [stcg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output stcg_pkg::cfg_t                      cfg
);
	import stcg_pkg::*;

	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic [MODE_BITS-1:0]  mode_q;
	logic                  far_q;
	logic [RATE_BITS-1:0]  rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= COORD_BITS'(RST_DISPLAY_WIDTH);
			height_q <= COORD_BITS'(RST_DISPLAY_HEIGHT);
			mode_q   <= MODE_NONE;
			far_q    <= 1'b0;
			rate_q   <= RST_PROGRESS_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISPLAY_WIDTH:   width_q  <= cfg_data[COORD_BITS-1:0];
				REG_DISPLAY_HEIGHT:  height_q <= cfg_data[COORD_BITS-1:0];
				REG_TRANSITION_MODE: mode_q   <= cfg_data[MODE_BITS-1:0];
				REG_WIPE_ORIGIN_FAR: far_q    <= cfg_data[0];
				REG_PROGRESS_RATE:   rate_q   <= cfg_data[RATE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.display_width   = CFG_DATA_BITS'(width_q);
	assign cfg.display_height  = CFG_DATA_BITS'(height_q);
	assign cfg.transition_mode = mode_q;
	assign cfg.wipe_origin_far = far_q;
	assign cfg.progress_rate   = rate_q;

endmodule

[hdl/stcg_mul.sv]
// shared multiplier with registered product
module stcg_mul #(
	parameter int OP_BITS = stcg_pkg::PROGRESS_FRAC_BITS_DEF + 2
) (
	input  logic                   clk,
	input  logic [OP_BITS-1:0]     a,
	input  logic [OP_BITS-1:0]     b,
	output logic [2*OP_BITS-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= (2*OP_BITS)'(a) * (2*OP_BITS)'(b);
	end

endmodule

[hdl/screen_transition_clip_generator_top.sv]
// clip generator top: tick sequencer and datapath around one shared multiplier
// a tick runs ST_ADV and ST_UPD, then ST_IRX and ST_IRY (iris) or ST_SQ, ST_CUB, ST_EASE and ST_SCL
// (wipe), then ST_FIN; each multiply step takes one pass through the shared multiplier, and
// the sequencer holds off the next tick until its word is loaded
// the clip register lets the next tick start while a finished word waits to be taken
// arst_n clears progress, the sequencer and output valid, and loads the register defaults
module screen_transition_clip_generator_top #(
	parameter int COORD_BITS         = stcg_pkg::COORD_BITS_DEF,
	parameter int PROGRESS_FRAC_BITS = stcg_pkg::PROGRESS_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [stcg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [stcg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	stcg_in_if.sink                             tick,
	stcg_out_if.source                          clip
);
	import stcg_pkg::*;

	localparam int F         = PROGRESS_FRAC_BITS;
	localparam int C         = COORD_BITS;
	localparam int PW        = F + 1;
	localparam int EW        = F + 2;
	localparam int OPW       = (EW > DT_BITS) ? EW : DT_BITS;
	localparam int PRW       = 2 * OPW;
	localparam int INC_SHIFT = RATE_POINT - F;
	localparam logic [PW-1:0] ONE       = {1'b1, {F{1'b0}}};
	localparam logic [EW-1:0] THREE_ONE = {2'b11, {F{1'b0}}};

	cfg_t              cfg;
	state_t            state_q, state_d;
	logic              restart_q;
	logic [DT_BITS-1:0] dt_q;
	logic [PW-1:0]     progress_q;
	logic [C-1:0]      x_q;
	logic [PW-1:0]     f_q;
	logic              out_valid_q;
	logic [C-1:0]      cx_q, cy_q, cw_q, ch_q;
	logic              fin_q;

	logic [OPW-1:0]    mul_a, mul_b;
	logic [PRW-1:0]    prod_q;

	logic [C-1:0]      disp_w, disp_h, dim, sz, yi;
	logic [MODE_BITS-1:0] mode;
	logic              horiz, grow;
	logic [PW-1:0]     t, p2, prog_next, s_cl, f_next;
	logic [EW-1:0]     ease_k;
	logic [PRW:0]      sum;
	logic [PRW-1:0]    s_full;
	logic [C-1:0]      cx_d, cy_d, cw_d, ch_d;

	logic              tick_ready_c, ld_out, upd_prog, ld_x, ld_f;

	stcg_cfg #(
		.COORD_BITS(COORD_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	stcg_mul #(
		.OP_BITS(OPW)
	) u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	assign disp_w = cfg.display_width[C-1:0];
	assign disp_h = cfg.display_height[C-1:0];
	assign mode   = cfg.transition_mode;
	assign horiz  = (mode == MODE_HWIPE_IN) || (mode == MODE_HWIPE_OUT);
	assign grow   = (mode == MODE_HWIPE_IN) || (mode == MODE_VWIPE_IN);
	assign dim    = horiz ? disp_w : disp_h;

	// iris uses linear progress, reversed for iris out
	assign t      = (mode == MODE_IRIS_IN) ? progress_q : ONE - progress_q;
	assign p2     = PW'(prod_q >> F);
	assign ease_k = THREE_ONE - (EW'(progress_q) << 1);

	assign sum       = (PRW+1)'(prod_q >> INC_SHIFT) + (PRW+1)'(progress_q);
	assign prog_next = (sum > (PRW+1)'(ONE)) ? ONE : sum[PW-1:0];

	assign s_full = prod_q >> F;
	assign s_cl   = (s_full > PRW'(ONE)) ? ONE : s_full[PW-1:0];
	assign f_next = grow ? s_cl : ONE - s_cl;

	assign sz = C'(prod_q >> F);
	assign yi = C'(prod_q >> (F + 1));

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ADV: begin
				mul_a = OPW'(dt_q);
				mul_b = OPW'(cfg.progress_rate);
			end
			ST_IRX: begin
				mul_a = OPW'(disp_w);
				mul_b = OPW'(t);
			end
			ST_IRY: begin
				mul_a = OPW'(disp_h);
				mul_b = OPW'(t);
			end
			ST_SQ: begin
				mul_a = OPW'(progress_q);
				mul_b = OPW'(progress_q);
			end
			ST_CUB: begin
				mul_a = OPW'(p2);
				mul_b = OPW'(ease_k);
			end
			ST_SCL: begin
				mul_a = OPW'(dim);
				mul_b = OPW'(f_q);
			end
			ST_FIN: begin
				// keep the last product stable while the word waits
				case (mode)
					MODE_IRIS_IN, MODE_IRIS_OUT: begin
						mul_a = OPW'(disp_h);
						mul_b = OPW'(t);
					end
					MODE_HWIPE_IN, MODE_HWIPE_OUT,
					MODE_VWIPE_IN, MODE_VWIPE_OUT: begin
						mul_a = OPW'(dim);
						mul_b = OPW'(f_q);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (tick.valid) state_d = ST_ADV;
			ST_ADV:  state_d = ST_UPD;
			ST_UPD: begin
				case (mode)
					MODE_IRIS_IN, MODE_IRIS_OUT: state_d = ST_IRX;
					MODE_HWIPE_IN, MODE_HWIPE_OUT,
					MODE_VWIPE_IN, MODE_VWIPE_OUT: state_d = ST_SQ;
					default: state_d = ST_FIN;
				endcase
			end
			ST_IRX:  state_d = ST_IRY;
			ST_IRY:  state_d = ST_FIN;
			ST_SQ:   state_d = ST_CUB;
			ST_CUB:  state_d = ST_EASE;
			ST_EASE: state_d = ST_SCL;
			ST_SCL:  state_d = ST_FIN;
			ST_FIN:  if (!out_valid_q || clip.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		tick_ready_c = 1'b0;
		upd_prog     = 1'b0;
		ld_x         = 1'b0;
		ld_f         = 1'b0;
		ld_out       = 1'b0;
		case (state_q)
			ST_IDLE: tick_ready_c = 1'b1;
			ST_UPD:  upd_prog     = 1'b1;
			ST_IRY:  ld_x         = 1'b1;
			ST_EASE: ld_f         = 1'b1;
			ST_FIN:  ld_out       = !out_valid_q || clip.ready;
			default: ;
		endcase
	end

	// clip rectangle from the finished computation
	always_comb begin
		cx_d = '0;
		cy_d = '0;
		cw_d = disp_w;
		ch_d = disp_h;
		case (mode)
			MODE_IRIS_IN, MODE_IRIS_OUT: begin
				cx_d = x_q;
				cy_d = yi;
				cw_d = disp_w - C'({x_q, 1'b0});
				ch_d = disp_h - C'({yi, 1'b0});
			end
			MODE_HWIPE_IN, MODE_HWIPE_OUT: begin
				cw_d = sz;
				cx_d = cfg.wipe_origin_far ? disp_w - sz : '0;
			end
			MODE_VWIPE_IN, MODE_VWIPE_OUT: begin
				ch_d = sz;
				cy_d = cfg.wipe_origin_far ? disp_h - sz : '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			progress_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_prog) begin
				progress_q <= restart_q ? '0 : prog_next;
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (clip.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick_ready_c) begin
			restart_q <= tick.restart;
			dt_q      <= tick.tick_dt;
		end
		if (ld_x) begin
			x_q <= yi;
		end
		if (ld_f) begin
			f_q <= f_next;
		end
		if (ld_out) begin
			cx_q  <= cx_d;
			cy_q  <= cy_d;
			cw_q  <= cw_d;
			ch_q  <= ch_d;
			fin_q <= (progress_q == ONE);
		end
	end

	assign tick.ready    = tick_ready_c;
	assign clip.valid    = out_valid_q;
	assign clip.clip_x   = cx_q;
	assign clip.clip_y   = cy_q;
	assign clip.clip_w   = cw_q;
	assign clip.clip_h   = ch_q;
	assign clip.finished = fin_q;

	a_prog_bound: assert property (@(posedge clk) disable iff (!arst_n)
		progress_q <= ONE)
		else $error("progress above one");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		tick.valid && tick.ready |=> state_q == ST_ADV)
		else $error("accepted word did not start the sequence");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && restart_q |=> progress_q == '0)
		else $error("restart did not clear progress");

	a_iris_span: assert property (@(posedge clk) disable iff (!arst_n)
		clip.valid && (mode == MODE_IRIS_IN || mode == MODE_IRIS_OUT)
		|-> C'({clip.clip_x, 1'b0} + (C+1)'(clip.clip_w)) == disp_w)
		else $error("iris window not centered on the display width");

endmodule

[tb/sv/tb_screen_transition_clip_generator_top.sv]
// self-checking testbench for the clip generator: tick driver, clip monitor and progress predictor
`timescale 1ns / 1ps

module tb_screen_transition_clip_generator_top;
	import stcg_pkg::*;

	localparam int          FRAC      = PROGRESS_FRAC_BITS_DEF;
	localparam logic [63:0] PROG_ONE  = 64'd1 << FRAC;
	localparam logic [2:0]  MODE_SPARE = 3'd7;

	typedef struct packed {
		logic        restart;
		logic [15:0] dt;
	} tick_word_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [11:0] w;
		logic [11:0] h;
		logic        fin;
	} clip_word_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	stcg_in_if tick_if ();
	stcg_out_if #(.COORD_W(COORD_BITS_DEF)) clip_if ();

	screen_transition_clip_generator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_if),
		.clip      (clip_if)
	);

	// shadow of the register file and of the progress accumulator
	logic [11:0] cfg_w = 12'(RST_DISPLAY_WIDTH);
	logic [11:0] cfg_h = 12'(RST_DISPLAY_HEIGHT);
	logic [2:0]  cfg_mode = MODE_NONE;
	logic        cfg_far = 1'b0;
	logic [15:0] cfg_rate = RST_PROGRESS_RATE;
	logic [63:0] prog_q = 64'd0;

	tick_word_t tick_q[$];
	clip_word_t clip_due_q[$];

	bit drv_busy;
	bit tick_took;
	int burst_left;
	int gap_left;
	int rx_mode;
	int rx_left;

	int n_err;
	int n_ticks;
	int n_restarts;
	int n_words;
	int n_fin;
	int n_mode[8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("timeout with %0d clip words still due", clip_due_q.size());
		$display("screen_transition_clip_generator_top regression: fail");
		$finish;
	end

	// progress update plus clip rectangle for one tick
	function automatic clip_word_t calc_clip(input logic restart, input logic [15:0] dt);
		logic [63:0] ww, hh, t, p2, s, f, x, y, w, h, inc;
		clip_word_t r;
		ww = 64'(cfg_w);
		hh = 64'(cfg_h);
		x = 64'd0;
		y = 64'd0;
		w = ww;
		h = hh;
		if (restart) begin
			prog_q = 64'd0;
		end else begin
			inc = (64'(dt) * 64'(cfg_rate)) >> (RATE_POINT - FRAC);
			prog_q = prog_q + inc;
			if (prog_q > PROG_ONE)
				prog_q = PROG_ONE;
		end
		case (cfg_mode)
			MODE_IRIS_IN, MODE_IRIS_OUT: begin
				t = (cfg_mode == MODE_IRIS_IN) ? prog_q : PROG_ONE - prog_q;
				x = (ww * t) >> (FRAC + 1);
				y = (hh * t) >> (FRAC + 1);
				w = ww - 2 * x;
				h = hh - 2 * y;
			end
			MODE_HWIPE_IN, MODE_HWIPE_OUT, MODE_VWIPE_IN, MODE_VWIPE_OUT: begin
				// smoothstep 3p^2 - 2p^3 in fixed point
				p2 = (prog_q * prog_q) >> FRAC;
				s = (p2 * (3 * PROG_ONE - 2 * prog_q)) >> FRAC;
				if (s > PROG_ONE)
					s = PROG_ONE;
				f = (cfg_mode == MODE_HWIPE_IN || cfg_mode == MODE_VWIPE_IN) ? s : PROG_ONE - s;
				if (cfg_mode == MODE_HWIPE_IN || cfg_mode == MODE_HWIPE_OUT) begin
					w = (ww * f) >> FRAC;
					x = cfg_far ? ww - w : 64'd0;
				end else begin
					h = (hh * f) >> FRAC;
					y = cfg_far ? hh - h : 64'd0;
				end
			end
			default: ;
		endcase
		r.x = x[11:0];
		r.y = y[11:0];
		r.w = w[11:0];
		r.h = h[11:0];
		r.fin = (prog_q == PROG_ONE);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned exp_v);
		n_err++;
		if (n_err <= 40)
			$display("mismatch at clip word %0d, %s: got %0d, expected %0d",
				n_words, what, got, exp_v);
	endtask

	// tick accept, clip word check
	always @(posedge clk) begin : watch
		clip_word_t got, want;
		if (arst_n) begin
			if (tick_if.valid && tick_if.ready) begin
				clip_due_q = {clip_due_q, calc_clip(tick_if.restart, tick_if.tick_dt)};
				n_ticks++;
				if (tick_if.restart)
					n_restarts++;
				n_mode[cfg_mode]++;
				tick_took = 1'b1;
			end
			if (clip_if.valid && clip_if.ready) begin
				if (clip_due_q.size() == 0) begin
					report_mismatch("word with nothing due", 0, 0);
				end else begin
					want = clip_due_q.pop_front();
					got.x = clip_if.clip_x;
					got.y = clip_if.clip_y;
					got.w = clip_if.clip_w;
					got.h = clip_if.clip_h;
					got.fin = clip_if.finished;
					if (got.x !== want.x)
						report_mismatch("clip_x", 32'(got.x), 32'(want.x));
					if (got.y !== want.y)
						report_mismatch("clip_y", 32'(got.y), 32'(want.y));
					if (got.w !== want.w)
						report_mismatch("clip_w", 32'(got.w), 32'(want.w));
					if (got.h !== want.h)
						report_mismatch("clip_h", 32'(got.h), 32'(want.h));
					if (got.fin !== want.fin)
						report_mismatch("finished", 32'(got.fin), 32'(want.fin));
					if (want.fin)
						n_fin++;
				end
				n_words++;
			end
		end
	end

	// tick driver: bursts of words with random gaps
	always @(negedge clk) begin : drive_ticks
		tick_word_t nxt;
		if (tick_took) begin
			drv_busy = 1'b0;
			tick_took = 1'b0;
		end
		if (!drv_busy && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
				tick_if.tick_dt <= 16'($urandom);
			end else if (tick_q.size() > 0) begin
				nxt = tick_q.pop_front();
				tick_if.restart <= nxt.restart;
				tick_if.tick_dt <= nxt.dt;
				drv_busy = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					case ($urandom_range(0, 3))
						0: begin
							gap_left = 0;
							burst_left = $urandom_range(100, 300);
						end
						1: begin
							gap_left = $urandom_range(1, 3);
							burst_left = $urandom_range(1, 20);
						end
						2: begin
							gap_left = $urandom_range(4, 9);
							burst_left = $urandom_range(1, 10);
						end
						default: begin
							gap_left = $urandom_range(10, 30);
							burst_left = $urandom_range(0, 5);
						end
					endcase
				end
			end
		end
		tick_if.valid <= drv_busy;
	end

	// clip receiver: stall pattern switches after a run of random length
	always @(negedge clk) begin : drive_ready
		logic rdy;
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(40, 400);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: rdy = 1'b1;
			1: rdy = 1'($urandom_range(0, 1));
			2: rdy = ($urandom_range(0, 5) == 0);
			default: rdy = 1'(rx_left >> 2);
		endcase
		clip_if.ready <= rdy;
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_DISPLAY_WIDTH:   cfg_w = val[11:0];
			REG_DISPLAY_HEIGHT:  cfg_h = val[11:0];
			REG_TRANSITION_MODE: cfg_mode = val[2:0];
			REG_WIPE_ORIGIN_FAR: cfg_far = val[0];
			REG_PROGRESS_RATE:   cfg_rate = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic setup_phase(input int w, input int h, input logic [2:0] mode,
			input logic far, input logic [15:0] rate);
		write_reg(REG_DISPLAY_WIDTH, 16'(w));
		write_reg(REG_DISPLAY_HEIGHT, 16'(h));
		write_reg(REG_TRANSITION_MODE, 16'(mode));
		write_reg(REG_WIPE_ORIGIN_FAR, 16'(far));
		write_reg(REG_PROGRESS_RATE, rate);
	endtask

	task automatic add_tick(input logic restart, input logic [15:0] dt);
		tick_word_t t;
		t.restart = restart;
		t.dt = dt;
		tick_q = {tick_q, t};
	endtask

	// wait for every word to drain, then let the sequencer settle
	task automatic wait_quiet();
		while (tick_q.size() != 0 || drv_busy || clip_due_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 1;
			2: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic logic [15:0] pick_rate();
		case ($urandom_range(0, 11))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3, 4, 5: return 16'($urandom_range(1, 16'h03FF));
			6, 7, 8: return 16'($urandom_range(16'h0400, 16'h3FFF));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_dt();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(1, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int rand_items;
		int n;
		int style;
		logic rs;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tick_if.valid = 1'b0;
		tick_if.restart = 1'b0;
		tick_if.tick_dt = '0;
		clip_if.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register defaults: full display, progress runs up to saturation
		add_tick(1'b1, 16'hFFFF);
		add_tick(1'b0, 16'h0000);
		add_tick(1'b0, 16'hFFFF);
		add_tick(1'b0, 16'hFFFF);
		wait_quiet();

		// largest display, iris in at the highest rate
		setup_phase(4095, 4095, MODE_IRIS_IN, 1'b0, 16'hFFFF);
		add_tick(1'b1, 16'h1234);
		add_tick(1'b0, 16'h0001);
		add_tick(1'b0, 16'hFFFF);
		wait_quiet();

		// zero rate leaves progress where it is
		setup_phase(4095, 200, MODE_HWIPE_OUT, 1'b1, 16'h0000);
		add_tick(1'b1, 16'h0000);
		add_tick(1'b0, 16'hFFFF);
		add_tick(1'b0, 16'h8000);
		wait_quiet();

		// empty display, far-anchored vertical wipe
		setup_phase(0, 0, MODE_VWIPE_OUT, 1'b1, 16'd300);
		add_tick(1'b1, 16'h0000);
		add_tick(1'b0, 16'h4000);
		add_tick(1'b0, 16'hFFFF);
		wait_quiet();

		// spare mode code behaves like no transition
		setup_phase(1, 4095, MODE_SPARE, 1'b1, 16'h0100);
		add_tick(1'b1, 16'h0000);
		add_tick(1'b0, 16'h9000);
		wait_quiet();

		setup_phase(4095, 1, MODE_IRIS_OUT, 1'b0, 16'h0001);
		add_tick(1'b1, 16'h0000);
		add_tick(1'b0, 16'hFFFF);
		wait_quiet();

		setup_phase(640, 480, MODE_VWIPE_IN, 1'b0, 16'h0100);
		add_tick(1'b1, 16'h0000);
		add_tick(1'b0, 16'h8000);
		add_tick(1'b0, 16'hFFFF);
		wait_quiet();

		// random phases: mostly restart-then-advance runs, some scattered restarts
		rand_items = 0;
		while (rand_items < 1950) begin
			setup_phase(pick_size(), pick_size(), 3'($urandom_range(0, 7)),
				1'($urandom_range(0, 1)), pick_rate());
			n = $urandom_range(20, 90);
			style = $urandom_range(0, 4);
			for (int i = 0; i < n; i++) begin
				if (style == 0)
					rs = ($urandom_range(0, 2) == 0);
				else
					rs = (i == 0) || ($urandom_range(0, 24) == 0);
				add_tick(rs, pick_dt());
			end
			rand_items += n;
			wait_quiet();
		end

		$display("%0d ticks (%0d restarts), %0d clip words, %0d at full progress",
			n_ticks, n_restarts, n_words, n_fin);
		$display("per mode: iris %0d/%0d, h-wipe %0d/%0d, v-wipe %0d/%0d, none %0d/%0d",
			n_mode[0], n_mode[1], n_mode[2], n_mode[3], n_mode[4], n_mode[5],
			n_mode[6], n_mode[7]);
		if (n_err == 0)
			$display("screen_transition_clip_generator_top regression: pass");
		else
			$display("screen_transition_clip_generator_top regression: fail");
		$finish;
	end

endmodule

[sim.f]
hdl/stcg_pkg.sv
hdl/stcg_in_if.sv
hdl/stcg_out_if.sv
hdl/stcg_cfg.sv
hdl/stcg_mul.sv
hdl/screen_transition_clip_generator_top.sv
tb/sv/tb_screen_transition_clip_generator_top.sv
